// ----- hw/rtl/tcr_pkg.sv -----
// Shared types, widths and constants of the triangle coverage rasterizer.
package tcr_pkg;

    localparam int MAX_TRIANGLES = 256;
    localparam int FRACTION_BITS = 12;
    localparam int COORD_BITS    = 26;
    localparam int WORLD_UNITS   = 5;

    localparam int TRI_IDX_W  = $clog2(MAX_TRIANGLES);
    localparam int TRI_CNT_W  = $clog2(MAX_TRIANGLES + 1);
    localparam int VX_W       = 20;
    localparam int SIZE_W     = 13;
    localparam int PIX_W      = 12;
    localparam int COLOR_W    = 32;
    localparam int PROD_W     = VX_W + SIZE_W + 1;
    localparam int REM_W      = $clog2(WORLD_UNITS);
    localparam int DIV_SPLIT  = PROD_W / 2;
    localparam int DIV_IN_W   = DIV_SPLIT + REM_W;
    localparam int RECIP_SH   = DIV_IN_W + REM_W;
    localparam int RECIP_W    = RECIP_SH - REM_W + 1;
    localparam int DIV_Q_W    = DIV_IN_W - REM_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(WORLD_UNITS) - 64'd1) / 64'(WORLD_UNITS));
    localparam int SUM_W      = PROD_W + 2;
    localparam int VTX_W      = 2 * COORD_BITS;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int EPROD_W    = 2 * DIFF_W;
    localparam int EDGE_W     = EPROD_W + 1;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        EDGE_AB = 2'd0,
        EDGE_BC = 2'd1,
        EDGE_CA = 2'd2
    } edge_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_HI,
        ST_DIV_LO,
        ST_SAT,
        ST_WRITE,
        ST_QRD,
        ST_DIFF,
        ST_EMUL,
        ST_CHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic  capture;
        logic  clear;
        logic  q_init;
        logic  mul;
        logic  div_hi;
        logic  div_lo;
        logic  sat;
        logic  write_vtx;
        logic  rd;
        logic  diff;
        edge_t edge_sel;
        logic  emul;
        logic  tri_next;
        logic  set_hit;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic last_tri;
        logic edge_ok;
    } status_t;

endpackage

// ----- hw/rtl/tcr_ctrl.sv -----
// Controller state machine of the triangle coverage rasterizer.
module tcr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       op,
    input  tcr_pkg::status_t status,
    output tcr_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);
    import tcr_pkg::*;

    state_t               state_reg, state_next;
    edge_t                edge_reg, edge_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            edge_reg    <= EDGE_AB;
        end
        else
        begin
            state_reg   <= state_next;
            edge_reg    <= edge_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        edge_next    = edge_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_LOAD:  state_next = ST_MUL;
                        OP_QUERY: state_next = status.count_zero ? ST_DONE : ST_QRD;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL:    state_next = ST_DIV_HI;
            ST_DIV_HI: state_next = ST_DIV_LO;
            ST_DIV_LO: state_next = ST_SAT;
            ST_SAT:    state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_IDLE;
            ST_QRD:
            begin
                edge_next  = EDGE_AB;
                state_next = ST_DIFF;
            end
            ST_DIFF:  state_next = ST_EMUL;
            ST_EMUL:  state_next = ST_CHK;
            ST_CHK:
            begin
                if (!status.edge_ok)
                begin
                    state_next = status.last_tri ? ST_DONE : ST_QRD;
                end
                else if (edge_reg == EDGE_CA)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    edge_next  = (edge_reg == EDGE_AB) ? EDGE_BC : EDGE_CA;
                    state_next = ST_DIFF;
                end
            end
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.edge_sel = edge_reg;
        busy         = (state_reg != ST_IDLE);
        done         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = start;
                cmd.clear   = start && (op == OP_CLEAR);
                cmd.q_init  = start && (op == OP_QUERY);
            end
            ST_MUL:    cmd.mul       = 1'b1;
            ST_DIV_HI: cmd.div_hi    = 1'b1;
            ST_DIV_LO: cmd.div_lo    = 1'b1;
            ST_SAT:    cmd.sat       = 1'b1;
            ST_WRITE:  cmd.write_vtx = 1'b1;
            ST_QRD:    cmd.rd        = 1'b1;
            ST_DIFF:   cmd.diff      = 1'b1;
            ST_EMUL:   cmd.emul      = 1'b1;
            ST_CHK:
            begin
                cmd.tri_next = !status.edge_ok && !status.last_tri;
                cmd.set_hit  = status.edge_ok && (edge_reg == EDGE_CA);
            end
            ST_DONE:  done = 1'b1;
            default:  done = 1'b0;
        endcase
    end

endmodule

// ----- hw/rtl/tcr_dpath.sv -----
// Datapath of the triangle coverage rasterizer: projection, triangle memory and edge tests.
module tcr_dpath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tcr_pkg::cmd_t                         cmd,
    output tcr_pkg::status_t                      status,
    input  logic [tcr_pkg::SIZE_W-1:0]            screen_width,
    input  logic [tcr_pkg::SIZE_W-1:0]            screen_height,
    input  logic signed [tcr_pkg::VX_W-1:0]       vertex_x,
    input  logic signed [tcr_pkg::VX_W-1:0]       vertex_y,
    input  logic [tcr_pkg::PIX_W-1:0]             pixel_x,
    input  logic [tcr_pkg::PIX_W-1:0]             pixel_y,
    output logic [tcr_pkg::PIX_W-1:0]             out_x,
    output logic [tcr_pkg::PIX_W-1:0]             out_y,
    output logic                                  covered,
    output logic [tcr_pkg::COLOR_W-1:0]           color,
    output logic                                  overflowed
);
    import tcr_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(64'sd1 <<< (COORD_BITS - 1));

    logic signed [VX_W-1:0]        vx_reg, vy_reg;
    logic [PIX_W-1:0]              px_reg, py_reg;
    logic [TRI_CNT_W-1:0]          count_reg;
    logic [1:0]                    slot_reg;
    logic                          dropped_reg;
    logic [TRI_IDX_W-1:0]          tri_reg;
    logic                          hit_reg;

    logic [PROD_W-1:0]             numx_reg, numy_reg;
    logic [DIV_SPLIT-1:0]          qhx_reg, qhy_reg;
    logic                          negx_reg, negy_reg;
    logic signed [COORD_BITS-1:0]  sx_reg, sy_reg;

    logic [VTX_W-1:0]              vmem [3][MAX_TRIANGLES];
    logic [VTX_W-1:0]              rd_reg [3];

    logic signed [DIFF_W-1:0]      dy_reg, dx_reg, dpx_reg, dpy_reg;
    logic signed [EPROD_W-1:0]     p1_reg, p2_reg;

    logic signed [PROD_W-1:0]      prodx, prody;
    logic [REM_W-1:0]              rhx, rhy;
    logic [DIV_Q_W-1:0]            qlx, qly;
    logic signed [COORD_BITS-1:0]  ax, ay, bx, by;
    logic signed [DIFF_W-1:0]      ptx, pty;
    logic signed [EDGE_W-1:0]      edge_val;

    // Exact divide by five of a small operand by reciprocal multiplication.
    function automatic logic [DIV_Q_W-1:0] div5(input logic [DIV_IN_W-1:0] v);
        logic [DIV_IN_W+RECIP_W-1:0] p;
        p = (DIV_IN_W + RECIP_W)'(v) * (DIV_IN_W + RECIP_W)'(RECIP);
        return p[RECIP_SH+DIV_Q_W-1:RECIP_SH];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic [SIZE_W-1:0] size,
        input logic [PROD_W-1:0] quot,
        input logic              neg
    );
        logic signed [SUM_W-1:0] off;
        logic signed [SUM_W-1:0] q;
        logic signed [SUM_W-1:0] s;
        off = SUM_W'({size, {(FRACTION_BITS - 1){1'b0}}});
        q   = SUM_W'(quot);
        s   = neg ? (off - q) : (off + q);
        if (s > SAT_HI)
        begin
            s = SAT_HI;
        end
        else if (s < SAT_LO)
        begin
            s = SAT_LO;
        end
        return s[COORD_BITS-1:0];
    endfunction

    assign prodx = PROD_W'(vx_reg) * signed'(PROD_W'({1'b0, screen_height}));
    assign prody = PROD_W'(vy_reg) * signed'(PROD_W'({1'b0, screen_height}));
    assign rhx   = numx_reg[DIV_SPLIT+REM_W-1:DIV_SPLIT]
                   - qhx_reg[REM_W-1:0] * REM_W'(WORLD_UNITS);
    assign rhy   = numy_reg[DIV_SPLIT+REM_W-1:DIV_SPLIT]
                   - qhy_reg[REM_W-1:0] * REM_W'(WORLD_UNITS);
    assign qlx   = div5({rhx, numx_reg[DIV_SPLIT-1:0]});
    assign qly   = div5({rhy, numy_reg[DIV_SPLIT-1:0]});

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            vx_reg <= vertex_x;
            vy_reg <= vertex_y;
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if (cmd.mul)
        begin
            negx_reg <= prodx[PROD_W-1];
            negy_reg <= prody[PROD_W-1];
            numx_reg <= prodx[PROD_W-1] ? (~prodx + PROD_W'(WORLD_UNITS)) : prodx;
            numy_reg <= prody[PROD_W-1] ? (~prody + PROD_W'(WORLD_UNITS)) : prody;
        end
        else if (cmd.div_hi)
        begin
            qhx_reg <= DIV_SPLIT'(div5(DIV_IN_W'(numx_reg[PROD_W-1:DIV_SPLIT])));
            qhy_reg <= DIV_SPLIT'(div5(DIV_IN_W'(numy_reg[PROD_W-1:DIV_SPLIT])));
        end
        else if (cmd.div_lo)
        begin
            numx_reg <= {qhx_reg, qlx[DIV_SPLIT-1:0]};
            numy_reg <= {qhy_reg, qly[DIV_SPLIT-1:0]};
        end
        if (cmd.sat)
        begin
            sx_reg <= sat_coord(screen_width, numx_reg, negx_reg);
            sy_reg <= sat_coord(screen_height, numy_reg, negy_reg);
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_vmem
        always_ff @(posedge clk)
        begin
            if (cmd.write_vtx && (count_reg < TRI_CNT_W'(MAX_TRIANGLES))
                && (slot_reg == 2'(k)))
            begin
                vmem[k][count_reg[TRI_IDX_W-1:0]] <= {sx_reg, sy_reg};
            end
            if (cmd.rd)
            begin
                rd_reg[k] <= vmem[k][tri_reg];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            slot_reg    <= '0;
            dropped_reg <= 1'b0;
            tri_reg     <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg   <= '0;
                slot_reg    <= '0;
                dropped_reg <= 1'b0;
            end
            else if (cmd.write_vtx)
            begin
                if (slot_reg == 2'd2)
                begin
                    slot_reg <= '0;
                    if (count_reg < TRI_CNT_W'(MAX_TRIANGLES))
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_reg <= 1'b1;
                    end
                end
                else
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
            if (cmd.q_init)
            begin
                tri_reg <= '0;
                hit_reg <= 1'b0;
            end
            else
            begin
                if (cmd.tri_next)
                begin
                    tri_reg <= tri_reg + 1'b1;
                end
                if (cmd.set_hit)
                begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        case (cmd.edge_sel)
            EDGE_AB:
            begin
                {ax, ay} = rd_reg[0];
                {bx, by} = rd_reg[1];
            end
            EDGE_BC:
            begin
                {ax, ay} = rd_reg[1];
                {bx, by} = rd_reg[2];
            end
            EDGE_CA:
            begin
                {ax, ay} = rd_reg[2];
                {bx, by} = rd_reg[0];
            end
            default:
            begin
                {ax, ay} = rd_reg[0];
                {bx, by} = rd_reg[1];
            end
        endcase
    end

    assign ptx = signed'(DIFF_W'({px_reg, {FRACTION_BITS{1'b0}}}));
    assign pty = signed'(DIFF_W'({py_reg, {FRACTION_BITS{1'b0}}}));

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            dy_reg  <= DIFF_W'(by) - DIFF_W'(ay);
            dx_reg  <= DIFF_W'(bx) - DIFF_W'(ax);
            dpx_reg <= ptx - DIFF_W'(ax);
            dpy_reg <= pty - DIFF_W'(ay);
        end
        if (cmd.emul)
        begin
            p1_reg <= EPROD_W'(dy_reg) * EPROD_W'(dpx_reg);
            p2_reg <= EPROD_W'(dx_reg) * EPROD_W'(dpy_reg);
        end
    end

    assign edge_val = EDGE_W'(p1_reg) - EDGE_W'(p2_reg);

    assign status.count_zero = (count_reg == '0);
    assign status.last_tri   = ((TRI_CNT_W'(tri_reg) + 1'b1) == count_reg);
    assign status.edge_ok    = (edge_val <= 0);

    assign out_x      = px_reg;
    assign out_y      = py_reg;
    assign covered    = hit_reg;
    assign color      = {COLOR_W{hit_reg}};
    assign overflowed = dropped_reg;

endmodule

// ----- hw/rtl/triangle_coverage_rasterizer_unit.sv -----
// Top level of the triangle coverage rasterizer: command port, register port and checks.
// A command is taken when start is high and busy is low. A vertex load keeps busy high through
// the multiply by the screen height, two reciprocal-multiply steps of the divide by five,
// saturation and the memory write. A pixel query walks at most the N stored triangles (N up
// to 256) before its answer beat: each triangle takes one memory read and then a difference,
// a multiply and a check step for each edge tested, and the walk stops at the first covering
// triangle. A clear or an unused op does not raise busy. The answer appears on out_x, out_y,
// covered, color and overflowed for the single cycle that done is high; the receiver cannot
// stall it, so it must take every beat when it is shown.
module triangle_coverage_rasterizer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        op,
    input  logic signed [tcr_pkg::VX_W-1:0]   vertex_x,
    input  logic signed [tcr_pkg::VX_W-1:0]   vertex_y,
    input  logic [tcr_pkg::PIX_W-1:0]         pixel_x,
    input  logic [tcr_pkg::PIX_W-1:0]         pixel_y,
    output logic                              done,
    output logic [tcr_pkg::PIX_W-1:0]         out_x,
    output logic [tcr_pkg::PIX_W-1:0]         out_y,
    output logic                              covered,
    output logic [tcr_pkg::COLOR_W-1:0]       color,
    output logic                              overflowed,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcr_pkg::ADDR_W-1:0]        paddr,
    input  logic [tcr_pkg::DATA_W-1:0]        pwdata,
    output logic [tcr_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);
    import tcr_pkg::*;

    logic [SIZE_W-1:0] width_reg, height_reg;
    cmd_t              cmd;
    status_t           status;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(640);
            height_reg <= SIZE_W'(640);
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                height_reg <= pwdata[SIZE_W-1:0];
            end
            else
            begin
                width_reg <= pwdata[SIZE_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? DATA_W'(height_reg) : DATA_W'(width_reg);

    tcr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tcr_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .out_x         (out_x),
        .out_y         (out_y),
        .covered       (covered),
        .color         (color),
        .overflowed    (overflowed)
    );

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy stayed high after a result beat");

    a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_QUERY)) |=> busy)
        else $error("accepted query did not raise busy");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_LOAD)) |=> (busy && !done))
        else $error("vertex load produced a result beat");

endmodule
